FILE: hdl/lpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lpd_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int TIME_WIDTH = 48;
	localparam int SCAN_W = 48;
	localparam int ARATE_W = 40;
	localparam int AXIS_W = 32;
	localparam int TRATE_W = 40;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;

	localparam logic [2:0] REG_SCAN_END = 3'd0;
	localparam logic [2:0] REG_ANGLE_RATE = 3'd1;
	localparam logic [2:0] REG_AXIS_X = 3'd2;
	localparam logic [2:0] REG_AXIS_Y = 3'd3;
	localparam logic [2:0] REG_AXIS_Z = 3'd4;
	localparam logic [2:0] REG_TRATE_X = 3'd5;
	localparam logic [2:0] REG_TRATE_Y = 3'd6;
	localparam logic [2:0] REG_TRATE_Z = 3'd7;

	localparam int PROD_W = TIME_WIDTH + ARATE_W;
	localparam int ANG_W = 51;
	localparam int NGRP = (PROD_W - ANG_W + 7) / 8;
	localparam int NSLOT = NGRP + 1;
	localparam int GRP_W = ANG_W + 3;
	localparam int RED_W = ANG_W + 6;
	localparam int H_W = RED_W - ANG_W;
	localparam int A_W = ANG_W + 1;

	localparam logic [ANG_W-1:0] ANG_TWO_PI = 51'h6487ED5110B46;
	localparam logic [ANG_W-1:0] ANG_PI = 51'h3243F6A8885A3;
	localparam logic [ANG_W-1:0] ANG_HALF_PI = 51'h1921FB54442D2;

	localparam int CORDIC_STEPS = 31;
	localparam int Z_W = 34;
	localparam int CS_W = 32;
	localparam int V_W = 33;
	localparam int P_W = 34;
	localparam int M_W = 38;
	localparam int M_LO_W = M_W / 2;
	localparam int M_HI_W = M_W - M_LO_W;
	localparam int ACC_W = TIME_WIDTH + TRATE_W + 8;
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint CORDIC_GAIN = 64'sd652032874;

	localparam logic signed [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
		32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159, 32'sd67021687,
		32'sd33543516, 32'sd16775851, 32'sd8388437, 32'sd4194283, 32'sd2097149,
		32'sd1048576, 32'sd524288, 32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768,
		32'sd16384, 32'sd8192, 32'sd4096, 32'sd2048, 32'sd1024, 32'sd512, 32'sd256,
		32'sd128, 32'sd64, 32'sd32, 32'sd16, 32'sd8, 32'sd4, 32'sd2, 32'sd1
	};

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic signed [COORD_WIDTH-1:0] point_z;
		logic [TIME_WIDTH-1:0] point_time;
		logic point_valid;
	} lpd_in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] out_x;
		logic signed [COORD_WIDTH-1:0] out_y;
		logic signed [COORD_WIDTH-1:0] out_z;
		logic out_valid;
		logic time_clamped;
	} lpd_out_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] px;
		logic signed [COORD_WIDTH-1:0] py;
		logic signed [COORD_WIDTH-1:0] pz;
		logic [TIME_WIDTH-1:0] dt;
		logic late;
		logic pv;
		logic zero;
		logic flip;
	} lpd_side_t;

	typedef logic [PROD_W-1:0][ANG_W-1:0] lpd_res_tbl_t;
	typedef logic [NGRP-1:0][255:0][GRP_W-1:0] lpd_grp_tbl_t;
	typedef logic [(2**H_W)-1:0][ANG_W-1:0] lpd_fold_tbl_t;

	// residue of each power of two modulo two pi
	function automatic lpd_res_tbl_t build_res();
		lpd_res_tbl_t t;
		logic [ANG_W:0] r;
		r = (ANG_W+1)'(1);
		for (int n = 0; n < PROD_W; n++) begin
			t[n] = r[ANG_W-1:0];
			r = r << 1;
			if (r >= {1'b0, ANG_TWO_PI}) begin
				r = r - {1'b0, ANG_TWO_PI};
			end
		end
		return t;
	endfunction

	localparam lpd_res_tbl_t RES_TBL = build_res();

	function automatic lpd_grp_tbl_t build_grp();
		lpd_grp_tbl_t t;
		logic [GRP_W-1:0] acc;
		logic [7:0] vb;
		for (int g = 0; g < NGRP; g++) begin
			for (int v = 0; v < 256; v++) begin
				acc = '0;
				vb = 8'(v);
				for (int j = 0; j < 8; j++) begin
					if (vb[j] && (ANG_W + 8 * g + j) < PROD_W) begin
						acc = acc + GRP_W'(RES_TBL[ANG_W + 8 * g + j]);
					end
				end
				t[g][v] = acc;
			end
		end
		return t;
	endfunction

	function automatic lpd_fold_tbl_t build_fold();
		lpd_fold_tbl_t t;
		logic [ANG_W:0] acc;
		logic [H_W-1:0] hb;
		for (int h = 0; h < 2**H_W; h++) begin
			acc = '0;
			hb = H_W'(h);
			for (int j = 0; j < H_W; j++) begin
				if (hb[j]) begin
					acc = acc + (ANG_W+1)'(RES_TBL[ANG_W + j]);
					if (acc >= {1'b0, ANG_TWO_PI}) begin
						acc = acc - {1'b0, ANG_TWO_PI};
					end
				end
			end
			t[h] = acc[ANG_W-1:0];
		end
		return t;
	endfunction

	// q30 product rounded half up
	function automatic logic signed [P_W-1:0] mq30(
		input logic signed [V_W-1:0] a,
		input logic signed [V_W-1:0] b
	);
		logic signed [2*V_W-1:0] t;
		t = a * b + (2*V_W)'(64'sd536870912);
		return P_W'(t >>> 30);
	endfunction

endpackage
`default_nettype wire

FILE: hdl/lidar_point_deskew_core.sv
`timescale 1ns / 1ps
`default_nettype none
// lidar point deskew core
// input channel pt_valid/pt_ready/pt_data carries one point per transaction: Q16.16 x/y/z,
// capture time in microseconds and a validity flag. result channel res_valid/res_ready/
// res_data returns the point moved into the scan-end frame, in the same order.
// the APB port (64-bit data, register i at byte address 8*i) holds scan end time, angle
// rate, rotation axis and translation rates; write it only while no transaction is in flight.
// the pipeline has 10 stages of time difference, angle product and modulo reduction,
// 31 cordic stages (one rotation step each), 4 stages of quaternion and matrix products,
// 4 stages of matrix-vector sum and an output register with rounding and saturation.
// throughput is one point per cycle; the pipeline is a single chain of stages with a
// valid bit each, so a transaction enters on every cycle in which the output register is
// empty or being taken.
// when res_ready is low with a result waiting, the whole pipeline holds and pt_ready drops;
// nothing is lost or repeated. invalid points come out with their coordinates unchanged.
// reset clears the configuration registers to zero and empties the pipeline.
module lidar_point_deskew_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pt_valid,
	output logic pt_ready,
	input wire lpd_pkg::lpd_in_t pt_data,
	output logic res_valid,
	input wire logic res_ready,
	output lpd_pkg::lpd_out_t res_data,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [lpd_pkg::CFG_ADDR_W-1:0] paddr,
	input wire logic [lpd_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [lpd_pkg::CFG_DATA_W-1:0] prdata,
	output logic pready
);
	import lpd_pkg::*;

	localparam int NSTG = 49;
	localparam int DT_LO_W = TIME_WIDTH / 2;
	localparam int DT_HI_W = TIME_WIDTH - DT_LO_W;
	localparam int AR_LO_W = ARATE_W / 2;
	localparam int AR_HI_W = ARATE_W - AR_LO_W;
	localparam int TR_LO_W = TRATE_W / 2;
	localparam int TR_HI_W = TRATE_W - TR_LO_W;
	localparam int HS = (NSLOT + 1) / 2;
	localparam int PAD_W = ANG_W + 8 * NGRP;
	localparam int SH_W = ACC_W - 30;
	localparam lpd_grp_tbl_t GRP_TBL = build_grp();
	localparam lpd_fold_tbl_t FOLD_TBL = build_fold();
	localparam logic [ANG_W:0] TWO_TP = {ANG_TWO_PI, 1'b0};
	localparam logic signed [A_W-1:0] PI_S = {1'b0, ANG_PI};
	localparam logic signed [A_W-1:0] TWO_PI_S = {1'b0, ANG_TWO_PI};
	localparam logic signed [A_W-1:0] HALF_S = {1'b0, ANG_HALF_PI};
	localparam logic signed [A_W-1:0] ROUND_Z = A_W'(64'sd131072);
	localparam logic signed [Z_W-1:0] ZQ_LIM = Z_W'((HALF_S + ROUND_Z) >>> 18);
	localparam logic signed [ACC_W-1:0] ROUND_O = ACC_W'(64'sd536870912);
	localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic [SCAN_W-1:0] scan_end_q;
	logic [ARATE_W-1:0] arate_q;
	logic signed [AXIS_W-1:0] axis_q [3];
	logic signed [TRATE_W-1:0] trate_q [3];

	logic adv;
	logic vld_s [1:NSTG];
	lpd_side_t side_s [1:NSTG];
	lpd_side_t side1_d, side10_d;
	logic res_valid_q;
	lpd_out_t res_data_q;

	logic [DT_LO_W+AR_LO_W-1:0] pp_ll_s2;
	logic [DT_LO_W+AR_HI_W-1:0] pp_lh_s2;
	logic [DT_HI_W+AR_LO_W-1:0] pp_hl_s2;
	logic [DT_HI_W+AR_HI_W-1:0] pp_hh_s2;
	logic [PROD_W-1:0] prod_s3;
	logic [PAD_W-1:0] prod_pad;
	logic [GRP_W-1:0] slot_s4 [NSLOT];
	logic [RED_W-1:0] half_d [2];
	logic [RED_W-1:0] half_s5 [2];
	logic [RED_W-1:0] sum_s6;
	logic [ANG_W:0] tsum_s7;
	logic [ANG_W-1:0] red_d, red_s8;
	logic signed [A_W-1:0] ang_s9;
	logic signed [A_W-1:0] fold_a, fold_r;
	logic fold_flip;
	logic signed [Z_W-1:0] zq_d, zq_s10;

	logic signed [Z_W-1:0] cx_s [CORDIC_STEPS];
	logic signed [Z_W-1:0] cy_s [CORDIC_STEPS];
	logic signed [Z_W-1:0] cz_s [CORDIC_STEPS];
	logic signed [Z_W-1:0] nx [CORDIC_STEPS];
	logic signed [Z_W-1:0] ny [CORDIC_STEPS];
	logic signed [Z_W-1:0] nz [CORDIC_STEPS];
	logic signed [Z_W-1:0] xi, yi, zi, ati;

	logic signed [Z_W-1:0] c_d, s_d;
	logic signed [CS_W-1:0] c_s42, s_s42, c_s43;
	logic signed [V_W-1:0] v_s43 [3];
	logic signed [P_W-1:0] xx_s44, yy_s44, zz_s44, xy_s44, xz_s44, yz_s44;
	logic signed [P_W-1:0] wx_s44, wy_s44, wz_s44;
	logic signed [M_W-1:0] mat_s45 [3][3];
	logic signed [M_LO_W+COORD_WIDTH:0] plo_s46 [3][3];
	logic signed [M_HI_W+COORD_WIDTH-1:0] phi_s46 [3][3];
	logic [DT_LO_W+TR_LO_W-1:0] tll_s46 [3];
	logic signed [DT_LO_W+TR_HI_W:0] tlh_s46 [3];
	logic [DT_HI_W+TR_LO_W-1:0] thl_s46 [3];
	logic signed [DT_HI_W+TR_HI_W:0] thh_s46 [3];
	logic signed [COORD_WIDTH-1:0] pvec [3];
	logic signed [ACC_W-1:0] el_s47 [3][3];
	logic signed [ACC_W-1:0] tr_s47 [3];
	logic signed [ACC_W-1:0] row_s48 [3];
	logic signed [ACC_W-1:0] tr_s48 [3];
	logic signed [ACC_W-1:0] acc_s49 [3];
	logic signed [SH_W-1:0] sh;
	logic signed [COORD_WIDTH-1:0] sat_d [3];
	lpd_out_t res_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_end_q <= '0;
			arate_q <= '0;
			for (int i = 0; i < 3; i++) begin
				axis_q[i] <= '0;
				trate_q[i] <= '0;
			end
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[5:3])
				REG_SCAN_END: scan_end_q <= pwdata[SCAN_W-1:0];
				REG_ANGLE_RATE: arate_q <= pwdata[ARATE_W-1:0];
				REG_AXIS_X: axis_q[0] <= pwdata[AXIS_W-1:0];
				REG_AXIS_Y: axis_q[1] <= pwdata[AXIS_W-1:0];
				REG_AXIS_Z: axis_q[2] <= pwdata[AXIS_W-1:0];
				REG_TRATE_X: trate_q[0] <= pwdata[TRATE_W-1:0];
				REG_TRATE_Y: trate_q[1] <= pwdata[TRATE_W-1:0];
				REG_TRATE_Z: trate_q[2] <= pwdata[TRATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			REG_SCAN_END: prdata = CFG_DATA_W'(scan_end_q);
			REG_ANGLE_RATE: prdata = CFG_DATA_W'(arate_q);
			REG_AXIS_X: prdata = CFG_DATA_W'(axis_q[0]);
			REG_AXIS_Y: prdata = CFG_DATA_W'(axis_q[1]);
			REG_AXIS_Z: prdata = CFG_DATA_W'(axis_q[2]);
			REG_TRATE_X: prdata = CFG_DATA_W'(trate_q[0]);
			REG_TRATE_Y: prdata = CFG_DATA_W'(trate_q[1]);
			REG_TRATE_Z: prdata = CFG_DATA_W'(trate_q[2]);
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// pipeline control
	assign adv = !res_valid_q || res_ready;
	assign pt_ready = adv;
	assign res_valid = res_valid_q;
	assign res_data = res_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTG; k++) begin
				vld_s[k] <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= pt_valid;
			for (int k = 2; k <= NSTG; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			res_valid_q <= vld_s[NSTG];
		end
	end

	// stage 1: time difference
	always_comb begin
		logic [TIME_WIDTH-1:0] se_w;
		se_w = TIME_WIDTH'(scan_end_q);
		side1_d.px = pt_data.point_x;
		side1_d.py = pt_data.point_y;
		side1_d.pz = pt_data.point_z;
		side1_d.pv = pt_data.point_valid;
		side1_d.late = pt_data.point_time > se_w;
		side1_d.dt = side1_d.late ? '0 : se_w - pt_data.point_time;
		side1_d.zero = 1'b0;
		side1_d.flip = 1'b0;
	end

	// stages 5, 8, 9, 10: modulo reduction and fold
	always_comb begin
		half_d[0] = '0;
		half_d[1] = '0;
		for (int k = 0; k < NSLOT; k++) begin
			if (k < HS) begin
				half_d[0] = half_d[0] + RED_W'(slot_s4[k]);
			end else begin
				half_d[1] = half_d[1] + RED_W'(slot_s4[k]);
			end
		end
	end

	always_comb begin
		if (tsum_s7 >= TWO_TP) begin
			red_d = ANG_W'(tsum_s7 - TWO_TP);
		end else if (tsum_s7 >= {1'b0, ANG_TWO_PI}) begin
			red_d = ANG_W'(tsum_s7 - {1'b0, ANG_TWO_PI});
		end else begin
			red_d = tsum_s7[ANG_W-1:0];
		end
	end

	always_comb begin
		fold_a = ang_s9;
		fold_flip = 1'b0;
		if (ang_s9 > HALF_S) begin
			fold_a = ang_s9 - PI_S;
			fold_flip = 1'b1;
		end else if (ang_s9 < -HALF_S) begin
			fold_a = ang_s9 + PI_S;
			fold_flip = 1'b1;
		end
		fold_r = fold_a + ROUND_Z;
		zq_d = Z_W'(fold_r >>> 18);
		side10_d = side_s[9];
		side10_d.zero = (zq_d == '0);
		side10_d.flip = fold_flip;
	end

	// cordic steps, one per stage
	always_comb begin
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			if (k == 0) begin
				xi = Z_W'(CORDIC_GAIN);
				yi = '0;
				zi = zq_s10;
			end else begin
				xi = cx_s[k-1];
				yi = cy_s[k-1];
				zi = cz_s[k-1];
			end
			ati = Z_W'(ATAN_Q30[k]);
			if (zi >= 0) begin
				nx[k] = xi - (yi >>> k);
				ny[k] = yi + (xi >>> k);
				nz[k] = zi - ati;
			end else begin
				nx[k] = xi + (yi >>> k);
				ny[k] = yi - (xi >>> k);
				nz[k] = zi + ati;
			end
		end
	end

	always_comb begin
		c_d = side_s[41].zero ? Z_W'(Q30_ONE) : cx_s[CORDIC_STEPS-1];
		s_d = side_s[41].zero ? '0 : cy_s[CORDIC_STEPS-1];
		if (side_s[41].flip) begin
			c_d = -c_d;
			s_d = -s_d;
		end
	end

	assign pvec[0] = side_s[45].px;
	assign pvec[1] = side_s[45].py;
	assign pvec[2] = side_s[45].pz;

	// output rounding, saturation and pass-through
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sh = SH_W'(acc_s49[r] >>> 30);
			if (sh > SH_W'(CMAX)) begin
				sat_d[r] = CMAX;
			end else if (sh < SH_W'(CMIN)) begin
				sat_d[r] = CMIN;
			end else begin
				sat_d[r] = sh[COORD_WIDTH-1:0];
			end
		end
		if (side_s[NSTG].pv) begin
			res_d.out_x = sat_d[0];
			res_d.out_y = sat_d[1];
			res_d.out_z = sat_d[2];
			res_d.out_valid = 1'b1;
			res_d.time_clamped = side_s[NSTG].late;
		end else begin
			res_d.out_x = side_s[NSTG].px;
			res_d.out_y = side_s[NSTG].py;
			res_d.out_z = side_s[NSTG].pz;
			res_d.out_valid = 1'b0;
			res_d.time_clamped = 1'b0;
		end
	end

	assign prod_pad = PAD_W'(prod_s3);

	// datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[1] <= side1_d;
			for (int k = 2; k < 10; k++) begin
				side_s[k] <= side_s[k-1];
			end
			side_s[10] <= side10_d;
			for (int k = 11; k <= NSTG; k++) begin
				side_s[k] <= side_s[k-1];
			end

			pp_ll_s2 <= side_s[1].dt[DT_LO_W-1:0] * arate_q[AR_LO_W-1:0];
			pp_lh_s2 <= side_s[1].dt[DT_LO_W-1:0] * arate_q[ARATE_W-1:AR_LO_W];
			pp_hl_s2 <= side_s[1].dt[TIME_WIDTH-1:DT_LO_W] * arate_q[AR_LO_W-1:0];
			pp_hh_s2 <= side_s[1].dt[TIME_WIDTH-1:DT_LO_W] * arate_q[ARATE_W-1:AR_LO_W];

			prod_s3 <= PROD_W'(pp_ll_s2) + (PROD_W'(pp_lh_s2) << AR_LO_W)
				+ (PROD_W'(pp_hl_s2) << DT_LO_W) + (PROD_W'(pp_hh_s2) << (DT_LO_W + AR_LO_W));

			slot_s4[0] <= GRP_W'(prod_s3[ANG_W-1:0]);
			for (int g = 0; g < NGRP; g++) begin
				slot_s4[g+1] <= GRP_TBL[g][prod_pad[ANG_W + 8 * g +: 8]];
			end

			half_s5[0] <= half_d[0];
			half_s5[1] <= half_d[1];
			sum_s6 <= half_s5[0] + half_s5[1];
			tsum_s7 <= (ANG_W+1)'(sum_s6[ANG_W-1:0])
				+ (ANG_W+1)'(FOLD_TBL[sum_s6[RED_W-1:ANG_W]]);
			red_s8 <= red_d;
			ang_s9 <= (red_s8 > ANG_PI) ? $signed({1'b0, red_s8}) - TWO_PI_S
				: $signed({1'b0, red_s8});
			zq_s10 <= zq_d;

			for (int k = 0; k < CORDIC_STEPS; k++) begin
				cx_s[k] <= nx[k];
				cy_s[k] <= ny[k];
				cz_s[k] <= nz[k];
			end

			c_s42 <= CS_W'(c_d);
			s_s42 <= CS_W'(s_d);

			c_s43 <= c_s42;
			for (int i = 0; i < 3; i++) begin
				v_s43[i] <= V_W'(mq30(V_W'(s_s42), V_W'(axis_q[i])));
			end

			xx_s44 <= mq30(v_s43[0], v_s43[0]);
			yy_s44 <= mq30(v_s43[1], v_s43[1]);
			zz_s44 <= mq30(v_s43[2], v_s43[2]);
			xy_s44 <= mq30(v_s43[0], v_s43[1]);
			xz_s44 <= mq30(v_s43[0], v_s43[2]);
			yz_s44 <= mq30(v_s43[1], v_s43[2]);
			wx_s44 <= mq30(V_W'(c_s43), v_s43[0]);
			wy_s44 <= mq30(V_W'(c_s43), v_s43[1]);
			wz_s44 <= mq30(V_W'(c_s43), v_s43[2]);

			mat_s45[0][0] <= M_W'(Q30_ONE) - ((M_W'(yy_s44) + M_W'(zz_s44)) <<< 1);
			mat_s45[0][1] <= (M_W'(xy_s44) - M_W'(wz_s44)) <<< 1;
			mat_s45[0][2] <= (M_W'(xz_s44) + M_W'(wy_s44)) <<< 1;
			mat_s45[1][0] <= (M_W'(xy_s44) + M_W'(wz_s44)) <<< 1;
			mat_s45[1][1] <= M_W'(Q30_ONE) - ((M_W'(xx_s44) + M_W'(zz_s44)) <<< 1);
			mat_s45[1][2] <= (M_W'(yz_s44) - M_W'(wx_s44)) <<< 1;
			mat_s45[2][0] <= (M_W'(xz_s44) - M_W'(wy_s44)) <<< 1;
			mat_s45[2][1] <= (M_W'(yz_s44) + M_W'(wx_s44)) <<< 1;
			mat_s45[2][2] <= M_W'(Q30_ONE) - ((M_W'(xx_s44) + M_W'(yy_s44)) <<< 1);

			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					plo_s46[r][c] <= $signed({1'b0, mat_s45[r][c][M_LO_W-1:0]}) * pvec[c];
					phi_s46[r][c] <= $signed(mat_s45[r][c][M_W-1:M_LO_W]) * pvec[c];
				end
				tll_s46[r] <= side_s[45].dt[DT_LO_W-1:0] * trate_q[r][TR_LO_W-1:0];
				tlh_s46[r] <= $signed({1'b0, side_s[45].dt[DT_LO_W-1:0]})
					* $signed(trate_q[r][TRATE_W-1:TR_LO_W]);
				thl_s46[r] <= side_s[45].dt[TIME_WIDTH-1:DT_LO_W] * trate_q[r][TR_LO_W-1:0];
				thh_s46[r] <= $signed({1'b0, side_s[45].dt[TIME_WIDTH-1:DT_LO_W]})
					* $signed(trate_q[r][TRATE_W-1:TR_LO_W]);
			end

			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					el_s47[r][c] <= ACC_W'(plo_s46[r][c]) + (ACC_W'(phi_s46[r][c]) <<< M_LO_W);
				end
				tr_s47[r] <= ACC_W'($signed({1'b0, tll_s46[r]}))
					+ (ACC_W'(tlh_s46[r]) <<< TR_LO_W)
					+ (ACC_W'($signed({1'b0, thl_s46[r]})) <<< DT_LO_W)
					+ (ACC_W'(thh_s46[r]) <<< (DT_LO_W + TR_LO_W));
			end

			for (int r = 0; r < 3; r++) begin
				row_s48[r] <= el_s47[r][0] + el_s47[r][1] + el_s47[r][2];
				tr_s48[r] <= tr_s47[r];
				acc_s49[r] <= row_s48[r] + (tr_s48[r] <<< 6) + ROUND_O;
			end

			res_data_q <= res_d;
		end
	end

	// checks
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready |-> !pt_ready)
		else $error("input taken while result stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && pt_ready |=> vld_s[1])
		else $error("accepted transaction not in first stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[10] |-> (zq_s10 <= ZQ_LIM) && (zq_s10 >= -ZQ_LIM))
		else $error("folded angle out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(!res_data_q.out_valid && res_data_q.time_clamped))
		else $error("clamp flag on invalid point");

endmodule
`default_nettype wire
